/* rtl/leb_pkg.sv */
// Shared types and constants for the LEB128 varint decoder.
`timescale 1ns / 1ps
`default_nettype none

package leb_pkg;

   // Encoding geometry
   localparam int unsigned ValueBits = 64;
   localparam int unsigned GroupBits = 7;
   localparam logic [3:0]  LastPos   = 4'd9;   // position of the tenth byte

   // Tenth-byte patterns that stay valid for the signed reading
   localparam logic [7:0] TenthZero = 8'h00;
   localparam logic [7:0] TenthOnes = 8'h7F;

   // Per-reading status codes
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_END     = 2'd2
   } status_type;

   // One decoded value as handed from the step logic to the result register
   typedef struct packed {
      logic [ValueBits-1:0] unsigned_value;
      status_type           unsigned_status;
      logic [ValueBits-1:0] signed_value;
      status_type           signed_status;
      logic [3:0]           byte_count;
   } result_type;

   // Decode state carried from one byte to the next
   typedef struct packed {
      logic [ValueBits-1:0] accum;
      logic [3:0]           pos;
   } state_type;

endpackage

`default_nettype wire

/* rtl/leb_step.sv */
// Combinational decode of one byte against the running accumulator.
`timescale 1ns / 1ps
`default_nettype none

module leb_step (
   input  wire leb_pkg::state_type  cur_state,
   input  wire logic [7:0]          data_byte,
   input  wire logic                first_of_value,
   input  wire logic                last_in_buffer,
   output leb_pkg::state_type       next_state,
   output logic                     res_valid,
   output leb_pkg::result_type      result
);

   logic [63:0] acc_eff;
   logic [3:0]  pos_raw;
   logic [3:0]  pos_eff;
   logic [5:0]  shift;
   logic [5:0]  top;
   logic [63:0] group;
   logic [63:0] v_mid;
   logic [63:0] v_tenth;
   logic [63:0] ext_mask;
   logic        cont;
   logic        sign_ok;

   // Restart drops any partial value; clamp position to the tenth byte
   always_comb begin
      acc_eff = first_of_value ? '0 : cur_state.accum;
      pos_raw = first_of_value ? '0 : cur_state.pos;
      pos_eff = (pos_raw > leb_pkg::LastPos) ? leb_pkg::LastPos : pos_raw;
   end

   // Place the 7-bit group above the bits gathered so far
   assign shift    = 6'(7'(pos_eff) * 7'(leb_pkg::GroupBits));
   assign top      = shift + 6'(leb_pkg::GroupBits);
   assign group    = {57'd0, data_byte[6:0]} << shift;
   assign v_mid    = acc_eff | group;
   assign v_tenth  = acc_eff | {data_byte[0], 63'd0};
   assign ext_mask = {64{1'b1}} << top;
   assign cont     = data_byte[7];
   assign sign_ok  = (data_byte == leb_pkg::TenthZero) || (data_byte == leb_pkg::TenthOnes);

   // Pick the ending case and form the next state
   always_comb begin
      next_state.accum       = '0;
      next_state.pos         = '0;
      res_valid              = 1'b1;
      result.unsigned_value  = '0;
      result.unsigned_status = leb_pkg::ST_OK;
      result.signed_value    = '0;
      result.signed_status   = leb_pkg::ST_OK;
      result.byte_count      = pos_eff + 4'd1;

      if (pos_eff == leb_pkg::LastPos) begin
         // Tenth byte always ends the value
         if (cont || (data_byte[6:1] != 6'd0)) begin
            result.unsigned_status = leb_pkg::ST_INVALID;
         end else begin
            result.unsigned_value = v_tenth;
         end
         if (sign_ok) begin
            result.signed_value = v_tenth;
         end else begin
            result.signed_status = leb_pkg::ST_INVALID;
         end
      end else if (cont) begin
         if (!last_in_buffer) begin
            // Keep gathering, no result yet
            res_valid            = 1'b0;
            next_state.accum     = v_mid;
            next_state.pos       = pos_eff + 4'd1;
         end else begin
            // Buffer ran out mid-value
            result.unsigned_status = leb_pkg::ST_END;
            result.signed_status   = leb_pkg::ST_END;
         end
      end else begin
         // Terminating byte: sign-extend from bit 6 of the group
         result.unsigned_value = v_mid;
         result.signed_value   = data_byte[6] ? (v_mid | ext_mask) : v_mid;
      end
   end

endmodule

`default_nettype wire

/* rtl/leb128_varint_decoder.sv */
// Results reach rsp_* through the input register, the step logic and the result
// register, a two-register path; the accumulator update is a single shift/mask/OR.
// Throughput: one byte per cycle while rsp_stall does not hold the result register.
// Reset (synchronous, active high) clears the accumulator, byte position and both
// valid flags; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module leb128_varint_decoder (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic               req_first_of_value,
   input  wire logic               req_last_in_buffer,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [63:0]             rsp_unsigned_value,
   output logic [1:0]              rsp_unsigned_status,
   output logic signed [63:0]      rsp_signed_value,
   output logic [1:0]              rsp_signed_status,
   output logic [3:0]              rsp_byte_count
);

   logic                 in_valid_ff;
   logic [7:0]           data_ff;
   logic                 first_ff;
   logic                 last_ff;
   leb_pkg::state_type   state_ff;
   leb_pkg::state_type   state_in;
   logic                 out_valid_ff;
   leb_pkg::result_type  out_ff;
   leb_pkg::result_type  step_res;
   logic                 step_valid;
   logic                 fire;

   // Decode the registered byte against the running state
   leb_step u_step (
      .cur_state      (state_ff),
      .data_byte      (data_ff),
      .first_of_value (first_ff),
      .last_in_buffer (last_ff),
      .next_state     (state_in),
      .res_valid      (step_valid),
      .result         (step_res)
   );

   // Advance the held byte when the result register has room
   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;

   // Input register: load a new transaction whenever it is not held
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall) begin
         data_ff  <= req_data_byte;
         first_ff <= req_first_of_value;
         last_ff  <= req_last_in_buffer;
      end
   end

   // Decode state: update once per decoded byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // Result register: load on a finished value, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire && step_valid) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (fire && step_valid) begin
         out_ff <= step_res;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_unsigned_value  = out_ff.unsigned_value;
   assign rsp_unsigned_status = out_ff.unsigned_status;
   assign rsp_signed_value    = out_ff.signed_value;
   assign rsp_signed_status   = out_ff.signed_status;
   assign rsp_byte_count      = out_ff.byte_count;

endmodule

`default_nettype wire
